// ===== hdl/brc_pkg.sv =====
// Shared constants and types for the barometer compensation pipeline.
package brc_pkg;

  localparam int BRC_T_NUM_W = 27;   // |mc << 11| fits in 27 bits
  localparam int BRC_T_DEN_W = 32;
  localparam int BRC_T_SIDE_W = 58;  // sign, zero-den, x1, up
  localparam int BRC_P_NUM_W = 33;   // b7 << 1
  localparam int BRC_P_DEN_W = 17;   // b4 = product >> 15
  localparam int BRC_P_SIDE_W = 18;  // fault, b7 msb, temperature
  localparam int BRC_LATENCY = 16 + BRC_T_NUM_W + BRC_P_NUM_W;

  localparam logic signed [31:0] BRC_B6_OFS   = 32'sd4000;
  localparam logic signed [31:0] BRC_C_SQ     = 32'sd3038;
  localparam logic signed [31:0] BRC_C_LIN    = -32'sd7357;
  localparam logic signed [31:0] BRC_C_OFS    = 32'sd3791;
  localparam logic [31:0]        BRC_P_SCALE  = 32'd50000;
  localparam logic signed [31:0] BRC_B4_OFS   = 32'sd32768;
  localparam logic signed [31:0] BRC_P_MAX    = 32'sd262143;

  typedef enum logic [2:0] {
    REG_A1_A2 = 3'd0,
    REG_A3_A4 = 3'd1,
    REG_A5_A6 = 3'd2,
    REG_B1_B2 = 3'd3,
    REG_MC_MD = 3'd4,
    REG_OSS   = 3'd5
  } brc_reg_t;

endpackage

// ===== hdl/brc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
module brc_div import brc_pkg::*; #(
  parameter int NUM_W  = BRC_P_NUM_W,
  parameter int DEN_W  = BRC_P_DEN_W,
  parameter int SIDE_W = BRC_P_SIDE_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  nq_r   [NUM_W];  // dividend bits out the top, quotient bits in below
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stg
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign nq_in   = in_num;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign nq_in   = nq_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      trial = {rem_in, nq_in[NUM_W-1]};
      diff  = trial - {1'b0, den_in};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      den_r[i]  <= den_in;
      side_r[i] <= side_in;
      if (!diff[DEN_W]) begin
        rem_r[i] <= diff[DEN_W-1:0];
        nq_r[i]  <= {nq_in[NUM_W-2:0], 1'b1};
      end else begin
        rem_r[i] <= trial[DEN_W-1:0];
        nq_r[i]  <= {nq_in[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign out_quo   = nq_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

// ===== hdl/barometer_raw_compensation.sv =====
// Barometer raw compensation: top level pipeline.
// Turns a raw temperature word and a raw 24-bit pressure reading into
// temperature in 0.1 C and pressure in Pa, using calibration coefficients
// written through the cfg_ port (cfg_valid/cfg_ready, cfg_index, cfg_data;
// cfg_ready is always high). Write configuration only while no item is in
// flight.
// An item is taken at a clock edge with start high and busy low; busy is
// high only during reset, so one item can enter every cycle.
// Each result shows on the out_ ports for one cycle with out_valid high,
// once its item has passed through every stage. The latency is set by two
// pipelined bit-per-stage dividers (27 and 33 stages) plus 16 arithmetic
// stages around them. Throughput is one item per cycle.
// out_divide_fault marks a zero divisor; temperature and pressure are then 0.
// Reset (rst_n low, synchronous) clears configuration and valid flags, drops
// every item in flight. The receiver cannot stall; the pipeline never holds.
module barometer_raw_compensation import brc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_raw_temperature,
  input  logic [23:0]        in_raw_pressure,
  output logic               out_valid,
  output logic signed [15:0] out_temperature_tenths,
  output logic [17:0]        out_pressure_pa,
  output logic               out_divide_fault,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // configuration
  logic [31:0] a1a2_r, a3a4_r, a5a6_r, b1b2_r, mcmd_r;
  logic [1:0]  oss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1a2_r <= '0;
      a3a4_r <= '0;
      a5a6_r <= '0;
      b1b2_r <= '0;
      mcmd_r <= '0;
      oss_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_A1_A2: a1a2_r <= cfg_data;
        REG_A3_A4: a3a4_r <= cfg_data;
        REG_A5_A6: a5a6_r <= cfg_data;
        REG_B1_B2: b1b2_r <= cfg_data;
        REG_MC_MD: mcmd_r <= cfg_data;
        REG_OSS:   oss_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = !rst_n;

  logic signed [31:0] ac1, ac2, ac3, b1, b2, md;
  logic [15:0] ac4, ac5, ac6, mc;
  assign ac1 = {{16{a1a2_r[31]}}, a1a2_r[31:16]};
  assign ac2 = {{16{a1a2_r[15]}}, a1a2_r[15:0]};
  assign ac3 = {{16{a3a4_r[31]}}, a3a4_r[31:16]};
  assign ac4 = a3a4_r[15:0];
  assign ac5 = a5a6_r[31:16];
  assign ac6 = a5a6_r[15:0];
  assign b1  = {{16{b1b2_r[31]}}, b1b2_r[31:16]};
  assign b2  = {{16{b1b2_r[15]}}, b1b2_r[15:0]};
  assign mc  = mcmd_r[31:16];
  assign md  = {{16{mcmd_r[15]}}, mcmd_r[15:0]};

  // valid bits of the arithmetic stages (indexes 1..16)
  logic [16:1] v_r;
  logic        tdv, pdv;

  // stage 1: (ut - ac6) * ac5
  logic [31:0] d1_r;
  logic [23:0] up1_r;
  // stage 2: x1, temperature divisor
  logic signed [31:0] x1_2_r, den2_r;
  logic [23:0] up2_r;
  // stage 3: magnitudes for the divider
  logic [BRC_T_NUM_W-1:0] nmag3_r;
  logic [31:0] dmag3_r;
  logic        neg3_r, fz3_r;
  logic signed [31:0] x1_3_r;
  logic [23:0] up3_r;

  logic [BRC_T_NUM_W-1:0]  tq;
  logic [BRC_T_SIDE_W-1:0] tside;

  // stages 4..11
  logic signed [31:0] b5_r, b6_r, sqm_r, m2_r, m3_r, m4_r, m5_r, x2a_r, x1b_r;
  logic signed [31:0] x3_r, s_r, b3_r, u_r, dlt_r;
  logic [31:0] b7_r;
  logic [16:0] b4_r, b4_11_r;
  logic signed [15:0] t5_r, t6_r, t7_r, t8_r, t9_r, t10_r, t11_r;
  logic [23:0] up4_r, up5_r, up6_r, up7_r, up8_r, up9_r;
  logic f4_r, f5_r, f6_r, f7_r, f8_r, f9_r, f10_r, f11_r;

  logic [BRC_P_NUM_W-1:0]  pq;
  logic [BRC_P_SIDE_W-1:0] pside;

  // stages 12..16
  logic signed [31:0] p12_r, p13_r, p14_r, p15_r, sqp_r, m7_r, m8_r, x2p_r, sum_r;
  logic signed [15:0] t12_r, t13_r, t14_r, t15_r;
  logic f12_r, f13_r, f14_r, f15_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r[1]     <= start && !busy;
      v_r[3:2]   <= v_r[2:1];
      v_r[4]     <= tdv;
      v_r[11:5]  <= v_r[10:4];
      v_r[12]    <= pdv;
      v_r[16:13] <= v_r[15:12];
    end
  end

  // front end
  logic signed [31:0] x1_c, den_c;
  logic [BRC_T_NUM_W-1:0] num_c;
  always_comb begin
    x1_c  = $signed(d1_r) >>> 15;
    den_c = x1_c + md;
    num_c = {mc, 11'b0};
  end

  always_ff @(posedge clk) begin
    d1_r    <= ({16'b0, in_raw_temperature} - {16'b0, ac6}) * {16'b0, ac5};
    up1_r   <= in_raw_pressure >> (4'd8 - {2'b0, oss_r});
    x1_2_r  <= x1_c;
    den2_r  <= den_c;
    up2_r   <= up1_r;
    nmag3_r <= mc[15] ? (~num_c + 1'b1) : num_c;
    dmag3_r <= den2_r[31] ? (~den2_r + 1'b1) : den2_r;
    neg3_r  <= mc[15] ^ den2_r[31];
    fz3_r   <= (den2_r == 32'sd0);
    x1_3_r  <= x1_2_r;
    up3_r   <= up2_r;
  end

  brc_div #(
    .NUM_W(BRC_T_NUM_W), .DEN_W(BRC_T_DEN_W), .SIDE_W(BRC_T_SIDE_W)
  ) u_tdiv (
    .clk(clk), .rst_n(rst_n), .in_valid(v_r[3]),
    .in_num(nmag3_r), .in_den(dmag3_r),
    .in_side({neg3_r, fz3_r, x1_3_r, up3_r}),
    .out_valid(tdv), .out_quo(tq), .out_side(tside)
  );

  // middle section
  logic signed [31:0] x2_c, t_c, b3s_c;
  logic [31:0] b4p_c;
  always_comb begin
    x2_c  = {{(32-BRC_T_NUM_W){1'b0}}, tq};
    if (tside[57]) x2_c = -x2_c;
    t_c   = (b5_r + 32'sd8) >>> 4;
    b3s_c = ($signed({ac1[29:0], 2'b0}) + x3_r) <<< oss_r;
    b4p_c = {16'b0, ac4} * u_r;
  end

  always_ff @(posedge clk) begin
    // stage 4
    b5_r  <= $signed(tside[55:24]) + x2_c;
    f4_r  <= tside[56];
    up4_r <= tside[23:0];
    // stage 5
    if (t_c > 32'sd32767)       t5_r <= 16'sh7FFF;
    else if (t_c < -32'sd32768) t5_r <= 16'sh8000;
    else                        t5_r <= t_c[15:0];
    b6_r  <= b5_r - BRC_B6_OFS;
    f5_r  <= f4_r;
    up5_r <= up4_r;
    // stage 6
    sqm_r <= b6_r * b6_r;
    m2_r  <= ac2 * b6_r;
    m3_r  <= ac3 * b6_r;
    t6_r  <= t5_r;
    f6_r  <= f5_r;
    up6_r <= up5_r;
    // stage 7
    m4_r  <= b2 * (sqm_r >>> 12);
    m5_r  <= b1 * (sqm_r >>> 12);
    x2a_r <= m2_r >>> 11;
    x1b_r <= m3_r >>> 13;
    t7_r  <= t6_r;
    f7_r  <= f6_r;
    up7_r <= up6_r;
    // stage 8
    x3_r  <= (m4_r >>> 11) + x2a_r;
    s_r   <= x1b_r + (m5_r >>> 16);
    t8_r  <= t7_r;
    f8_r  <= f7_r;
    up8_r <= up7_r;
    // stage 9
    b3_r  <= (b3s_c + 32'sd2) >>> 2;
    u_r   <= ((s_r + 32'sd2) >>> 2) + BRC_B4_OFS;
    t9_r  <= t8_r;
    f9_r  <= f8_r;
    up9_r <= up8_r;
    // stage 10
    b4_r  <= b4p_c[31:15];
    dlt_r <= $signed({8'b0, up9_r}) - b3_r;
    t10_r <= t9_r;
    f10_r <= f9_r;
    // stage 11
    b7_r    <= dlt_r * (BRC_P_SCALE >> oss_r);
    b4_11_r <= b4_r;
    t11_r   <= t10_r;
    f11_r   <= f10_r || (b4_r == 17'd0);
  end

  brc_div #(
    .NUM_W(BRC_P_NUM_W), .DEN_W(BRC_P_DEN_W), .SIDE_W(BRC_P_SIDE_W)
  ) u_pdiv (
    .clk(clk), .rst_n(rst_n), .in_valid(v_r[11]),
    .in_num({b7_r, 1'b0}), .in_den(b4_11_r),
    .in_side({f11_r, b7_r[31], t11_r}),
    .out_valid(pdv), .out_quo(pq), .out_side(pside)
  );

  // back end
  logic signed [31:0] a13_c, pf_c;
  always_comb begin
    a13_c = p12_r >>> 8;
    pf_c  = p15_r + (sum_r >>> 4);
  end

  always_ff @(posedge clk) begin
    // stage 12: for b7 >= 2^31 the quotient is (b7 / b4) << 1
    p12_r <= $signed({pq[31:1], pq[0] & !pside[16]});
    t12_r <= pside[15:0];
    f12_r <= pside[17];
    // stage 13
    sqp_r <= a13_c * a13_c;
    m7_r  <= BRC_C_LIN * p12_r;
    p13_r <= p12_r;
    t13_r <= t12_r;
    f13_r <= f12_r;
    // stage 14
    m8_r  <= sqp_r * BRC_C_SQ;
    x2p_r <= m7_r >>> 16;
    p14_r <= p13_r;
    t14_r <= t13_r;
    f14_r <= f13_r;
    // stage 15
    sum_r <= (m8_r >>> 16) + x2p_r + BRC_C_OFS;
    p15_r <= p14_r;
    t15_r <= t14_r;
    f15_r <= f14_r;
    // stage 16: output register
    out_divide_fault <= f15_r;
    if (f15_r) begin
      out_temperature_tenths <= '0;
      out_pressure_pa        <= '0;
    end else begin
      out_temperature_tenths <= t15_r;
      if (pf_c < 32'sd0)          out_pressure_pa <= '0;
      else if (pf_c > BRC_P_MAX)  out_pressure_pa <= '1;
      else                        out_pressure_pa <= pf_c[17:0];
    end
  end

  assign out_valid = v_r[16];

endmodule

// ===== hdl/brc_chk.sv =====
// Port-level checker for the barometer compensation block, bound to the top.
module brc_chk import brc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_temperature_tenths,
  input logic [17:0]        out_pressure_pa,
  input logic               out_divide_fault,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // every taken item comes out after the fixed latency
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##BRC_LATENCY out_valid)
    else $error("item did not produce a result on time");

  // no result without a matching item
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##BRC_LATENCY !out_valid)
    else $error("result without an item");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_fault) |->
      (out_temperature_tenths == 16'sd0 && out_pressure_pa == 18'd0))
    else $error("fault result not zeroed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

endmodule

bind barometer_raw_compensation brc_chk u_brc_chk (.*);
